/* design/cnmd_pkg.sv */
// ----------------------------------------------------------------------------
// cnmd_pkg: shared types and constants for the cellular noise distance unit
// Holds the point record passed from the front to the back and the hash
// constants of the feature point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnmd_pkg;

    // Scale factor fraction bits and feature point offset fraction bits.
    localparam int SCALE_FRAC = 16;
    localparam int OFS_FRAC   = 30;

    // Hash constants.
    localparam logic [31:0] HASH_MUL_X   = 32'd1619;
    localparam logic [31:0] HASH_MUL_Y   = 32'd31337;
    localparam logic [31:0] HASH_MUL_Z   = 32'd6971;
    localparam logic [31:0] HASH_MUL_S   = 32'd1013;
    localparam logic [31:0] HASH_MUL_SQ  = 32'd60493;
    localparam logic [31:0] HASH_ADD_SQ  = 32'd19990303;
    localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;
    localparam logic [31:0] HASH_MASK    = 32'h7fff_ffff;

    // Configuration register indexes.
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_SEED  = 1'b1;

    // Depth of the point queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One scaled point and its base cell, per axis x, y, z.
    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] b;
    } point_t;

    // Scaled coordinate from the unsigned product of magnitudes.
    function automatic logic [31:0] scale_sat(input logic [63:0] prod, input logic neg);
        logic [48:0] t;
        logic [31:0] q;
        if (neg) begin
            t = 49'((prod + 64'((1 << SCALE_FRAC) - 1)) >> SCALE_FRAC);
            if (t > 49'h0_8000_0000) q = 32'h8000_0000;
            else q = 32'(-t);
        end else begin
            t = 49'(prod >> SCALE_FRAC);
            if (t > 49'h0_7fff_ffff) q = 32'h7fff_ffff;
            else q = t[31:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

/* design/cnmd_front.sv */
// ----------------------------------------------------------------------------
// cnmd_front: input stage of the cellular noise distance unit
// Accepts points, scales them by the frequency and finds the base cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnmd_front
    import cnmd_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [95:0]  in_data,
    input  wire logic [31:0]  scale_factor,
    output logic              out_valid,
    input  wire logic         out_ready,
    output point_t            out_point
);

    logic             a_v_reg, b_v_reg, c_v_reg;
    logic [2:0][31:0] a_raw_reg;
    logic [2:0][63:0] b_prod_reg;
    logic [2:0]       b_neg_reg;
    logic [2:0][31:0] c_s_reg;
    logic             a_go, b_go, c_go;
    logic [2:0][31:0] mag;

    assign c_go     = !c_v_reg || out_ready;
    assign b_go     = !b_v_reg || c_go;
    assign a_go     = !a_v_reg || b_go;
    assign in_ready = a_go;

    // Stage valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            if (a_go) a_v_reg <= in_valid;
            if (b_go) b_v_reg <= a_v_reg;
            if (c_go) c_v_reg <= b_v_reg;
        end
    end

    // Magnitude of each coordinate; the most negative value stays 2^31.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = a_raw_reg[i][31] ? 32'(-a_raw_reg[i]) : a_raw_reg[i];
        end
    end

    // Capture, multiply, then round and saturate.
    always_ff @(posedge aclk) begin
        if (a_go) a_raw_reg <= in_data;
        if (b_go) begin
            for (int i = 0; i < 3; i++) begin
                b_prod_reg[i] <= 64'(mag[i]) * 64'(scale_factor);
                b_neg_reg[i]  <= a_raw_reg[i][31];
            end
        end
        if (c_go) begin
            for (int i = 0; i < 3; i++) begin
                c_s_reg[i] <= scale_sat(b_prod_reg[i], b_neg_reg[i]);
            end
        end
    end

    // Base cell: floor, one lower for a zero or negative integer.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_point.s[i] = c_s_reg[i];
            out_point.b[i] = 32'($signed(c_s_reg[i]) >>> COORD_FRAC_BITS)
                - ((($signed(c_s_reg[i]) <= 0)
                    && (c_s_reg[i][COORD_FRAC_BITS-1:0] == '0)) ? 32'd1 : 32'd0);
        end
    end

    assign out_valid = c_v_reg;

endmodule

`default_nettype wire

/* design/cnmd_queue.sv */
// ----------------------------------------------------------------------------
// cnmd_queue: point queue between front and back
// A small first-in first-out buffer of scaled points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnmd_queue
    import cnmd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  point_t    wr_point,
    output logic      rd_valid,
    input  wire logic rd_pop,
    output point_t    rd_point
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    point_t        mem [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_point = mem[rp_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= wr_point;
    end

endmodule

`default_nettype wire

/* design/cnmd_back.sv */
// ----------------------------------------------------------------------------
// cnmd_back: cell search of the cellular noise distance unit
// Walks the neighboring cells of one point, one per cycle while no finished result
// waits, through a pipelined hash and distance datapath, and keeps the smallest distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnmd_back
    import cnmd_pkg::*;
#(
    parameter int SEARCH_RADIUS   = 2,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        pt_valid,
    output logic             pt_pop,
    input  point_t           pt_point,
    input  wire logic [31:0] hash_seed,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [31:0]      res_data
);

    localparam int SPAN = 2 * SEARCH_RADIUS + 1;
    localparam int CW   = $clog2(SPAN);
    localparam int NST  = 6;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] s;
        logic             first;
        logic             last;
    } ctx_t;

    logic                en;
    logic [CW-1:0]       cnt_reg [3];
    logic                issue, at_end, at_start;
    logic [NST-1:0]      v_reg;
    ctx_t                ctx_reg [NST];
    logic [31:0]         base_reg;
    logic [2:0][31:0]    n_reg, sq_reg, t_reg, h_reg;
    logic [2:0][31:0]    n2_reg, n3_reg;
    logic [2:0][34:0]    u_reg;
    logic [2:0]          big_reg, big7_reg, big8_reg;
    logic [2:0][33:0]    aa_reg;
    logic [2:0][34:0]    ab_reg;
    logic [2:0][35:0]    bb_reg;
    logic [2:0][69:0]    sqd_reg;
    logic [3:0]          tv_reg;
    logic [3:0]          tfirst_reg, tlast_reg;
    logic [31:0]         cand_reg;
    logic [31:0]         best_reg, best_next;
    logic                out_v_reg;
    logic [31:0]         out_d_reg;
    logic [71:0]         sum;

    // The whole pipeline holds while a finished result waits.
    assign en = !(out_v_reg && !res_ready);

    // Cell walk: x inner, z outer.
    assign issue    = en && pt_valid;
    assign at_start = (cnt_reg[0] == '0) && (cnt_reg[1] == '0) && (cnt_reg[2] == '0);
    assign at_end   = (cnt_reg[0] == CW'(SPAN - 1)) && (cnt_reg[1] == CW'(SPAN - 1))
                      && (cnt_reg[2] == CW'(SPAN - 1));
    assign pt_pop   = issue && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) cnt_reg[i] <= '0;
        end else if (issue) begin
            if (cnt_reg[0] != CW'(SPAN - 1)) begin
                cnt_reg[0] <= cnt_reg[0] + 1'b1;
            end else begin
                cnt_reg[0] <= '0;
                if (cnt_reg[1] != CW'(SPAN - 1)) begin
                    cnt_reg[1] <= cnt_reg[1] + 1'b1;
                end else begin
                    cnt_reg[1] <= '0;
                    cnt_reg[2] <= (cnt_reg[2] != CW'(SPAN - 1)) ? cnt_reg[2] + 1'b1 : '0;
                end
            end
        end
    end

    // Valid bits of the datapath stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            tv_reg <= '0;
        end else if (en) begin
            v_reg  <= {v_reg[NST-2:0], pt_valid};
            tv_reg <= {tv_reg[2:0], v_reg[NST-1]};
        end
    end

    // Cell context shift line.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ctx_reg[0].c[i] <= pt_point.b[i] + 32'(cnt_reg[i]) - 32'(SEARCH_RADIUS);
            end
            ctx_reg[0].s     <= pt_point.s;
            ctx_reg[0].first <= at_start;
            ctx_reg[0].last  <= at_end;
            for (int k = 1; k < NST; k++) ctx_reg[k] <= ctx_reg[k-1];
            tfirst_reg <= {tfirst_reg[2:0], ctx_reg[NST-1].first};
            tlast_reg  <= {tlast_reg[2:0], ctx_reg[NST-1].last};
        end
    end

    // Hash stages: common sum, fold, square, polynomial, final product.
    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg <= 32'(HASH_MUL_X * ctx_reg[0].c[0]) + 32'(HASH_MUL_Y * ctx_reg[0].c[1])
                      + 32'(HASH_MUL_Z * ctx_reg[0].c[2]) + 32'(HASH_MUL_S * hash_seed);
            for (int i = 0; i < 3; i++) begin
                n_reg[i]  <= (((base_reg + 32'(HASH_MUL_S * 32'(i))) & HASH_MASK) >> 13)
                           ^ ((base_reg + 32'(HASH_MUL_S * 32'(i))) & HASH_MASK);
                sq_reg[i] <= 32'(n_reg[i] * n_reg[i]);
                t_reg[i]  <= 32'(sq_reg[i] * HASH_MUL_SQ) + HASH_ADD_SQ;
                h_reg[i]  <= (32'(n3_reg[i] * t_reg[i]) + HASH_ADD_OUT) & HASH_MASK;
            end
        end
    end

    // The folded hash value, kept in step with the polynomial stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            n2_reg <= n_reg;
            n3_reg <= n2_reg;
        end
    end

    // Axis differences against the feature point, in 30 fraction bits.
    always_ff @(posedge aclk) begin
        logic [65:0] cell1, st, d, ad;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cell1 = {{34{ctx_reg[5].c[i][31]}}, ctx_reg[5].c[i]} + 66'd1;
                st    = {{34{ctx_reg[5].s[i][31]}}, ctx_reg[5].s[i]};
                d     = (cell1 << OFS_FRAC) - 66'(h_reg[i])
                        - (st << (OFS_FRAC - COORD_FRAC_BITS));
                ad    = d[65] ? 66'(-d) : d;
                u_reg[i]   <= ad[34:0];
                big_reg[i] <= |ad[65:35];
            end
        end
    end

    // Square of each difference from three partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                aa_reg[i] <= 34'(u_reg[i][34:18]) * 34'(u_reg[i][34:18]);
                ab_reg[i] <= 35'(u_reg[i][34:18]) * 35'(u_reg[i][17:0]);
                bb_reg[i] <= 36'(u_reg[i][17:0]) * 36'(u_reg[i][17:0]);
                sqd_reg[i] <= (70'(aa_reg[i]) << 36) + (70'(ab_reg[i]) << 19)
                              + 70'(bb_reg[i]);
            end
            big7_reg <= big_reg;
            big8_reg <= big7_reg;
        end
    end

    // Half squared distance in Q8.24, saturated.
    assign sum = 72'(sqd_reg[0]) + 72'(sqd_reg[1]) + 72'(sqd_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            cand_reg <= ((|big8_reg) || (|sum[71:69])) ? 32'hffff_ffff : sum[68:37];
        end
    end

    // Running minimum and output register.
    always_comb begin
        if (tfirst_reg[3] || (cand_reg < best_reg)) best_next = cand_reg;
        else best_next = best_reg;
    end

    // While the pipeline moves, the output slot is either empty or being taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= tv_reg[3] && tlast_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tv_reg[3]) begin
            best_reg <= best_next;
            if (tlast_reg[3]) out_d_reg <= best_next;
        end
    end

    assign res_valid = out_v_reg;
    assign res_data  = out_d_reg;

endmodule

`default_nettype wire

/* design/cellular_noise_min_distance_unit.sv */
// ----------------------------------------------------------------------------
// cellular_noise_min_distance_unit: nearest feature point distance, 3D
// Scales a point, searches the neighboring cells and returns half of the
// smallest squared distance to a cell's feature point.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_axis  | in        | pos_x, pos_y, pos_z (signed, 32 bit each)
//  m_axis  | out       | half_min_sq_dist (unsigned Q8.24)
//  apb     | config    | scale_factor at 0x0, hash_seed at 0x4
//
// The cell search covers (2*SEARCH_RADIUS+1)^3 cells per point, 125 at the default
// radius, and issues one cell per cycle into the hash and distance pipeline while a
// point is queued and no finished result waits.
// Reset is synchronous and active low; it empties the queue and pipelines.
// A stalled result holds the search pipeline; the front keeps accepting
// until its three stages and its queue of four points are full.
`timescale 1ns / 1ps
`default_nettype none

module cellular_noise_min_distance_unit
    import cnmd_pkg::*;
#(
    parameter int SEARCH_RADIUS   = 2,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // half_min_sq_dist [31:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] scale_reg, seed_reg;
    logic        f_valid, f_ready, q_valid, q_pop;
    point_t      f_point, q_point;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 32'd65536;
            seed_reg  <= 32'd42;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_SCALE: scale_reg <= pwdata;
                REG_SEED:  seed_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : scale_reg;

    cnmd_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata),
        .scale_factor (scale_reg),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_point    (f_point)
    );

    cnmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_point (f_point),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_point (q_point)
    );

    cnmd_back #(
        .SEARCH_RADIUS  (SEARCH_RADIUS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pt_valid  (q_valid),
        .pt_pop    (q_pop),
        .pt_point  (q_point),
        .hash_seed (seed_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

endmodule

`default_nettype wire
